[hw/rtl/plcc_pkg.sv]
// Shared types and constants for the pinned LRU chunk cache.
package plcc_pkg;

  localparam int unsigned ChunkW    = 12;
  localparam int unsigned WordW     = 15;
  localparam int unsigned WordShift = 5;
  localparam int unsigned UsersW    = 8;
  localparam int unsigned SlotPortW = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 48;

  localparam logic [UsersW-1:0] UsersMax = '1;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_DIRTY   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_FREE   = 2'd1,
    ERR_UNUSED    = 2'd2,
    ERR_SATURATED = 2'd3
  } error_e;

  // One result, packed from the highest field down.
  typedef struct packed {
    error_e                 error;
    logic [ChunkW-1:0]      writeback_chunk;
    logic                   writeback_valid;
    logic [ChunkW-1:0]      fill_chunk;
    logic                   fill_valid;
    logic [WordW-1:0]       word_offset;
    logic                   hit;
    logic [SlotPortW-1:0]   slot_out;
  } result_t;

endpackage

[hw/rtl/pinned_lru_chunk_cache.sv]
// Pinned LRU chunk cache: tag, pin-count and LRU free-list manager.
//
// Usage
//   Requests enter on the s_axis channel: tuser carries the action (acquire,
//   release, mark dirty) and tdata the bit index and slot. Each request gives
//   exactly one result on the m_axis channel with the slot, hit flag, word
//   offset, fill and write-back requests and an error code.
//   A request is taken into an input register, the tag compare against all
//   slots and the free-list update are done combinationally from that
//   register, and the result lands in an output register. One request is
//   accepted every cycle while the receiver does not stall; the combinational
//   tag compare and free-list shift allow that rate.
//   State (tags, dirty flags, pin counts, free list) is written only when a
//   result is loaded into the output register, so back-to-back requests see
//   the effect of the one before.
//   When the receiver stalls, the output register holds its result and the
//   input register holds one more request; after that s_axis_tready drops.
//   Reset (rst_ni low, asynchronous) empties both registers, makes slot i
//   hold chunk i, clean and unpinned, with free list 0..SLOTS-1 oldest first.
module pinned_lru_chunk_cache #(
  parameter int unsigned SLOTS       = 4,
  parameter int unsigned CHUNK_SHIFT = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bit_index[31:0], slot[33:32], zero pad [39:34]
  input  logic [plcc_pkg::InDataW-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot_out[1:0], hit[2], word_offset[17:3], fill_valid[18], fill_chunk[30:19],
  // writeback_valid[31], writeback_chunk[43:32], error[45:44], zero pad [47:46]
  output logic [plcc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  // Input register
  logic                           in_valid_q;
  plcc_pkg::action_e              action_q;
  logic [31:0]                    bit_idx_q;
  logic [plcc_pkg::SlotPortW-1:0] slot_q;

  // Output register
  logic                           out_valid_q;
  plcc_pkg::result_t              res_q, res_d;

  // Cache state
  logic [plcc_pkg::ChunkW-1:0] chunk_q [SLOTS];
  logic [plcc_pkg::ChunkW-1:0] chunk_d [SLOTS];
  logic                        dirty_q [SLOTS];
  logic                        dirty_d [SLOTS];
  logic [plcc_pkg::UsersW-1:0] users_q [SLOTS];
  logic [plcc_pkg::UsersW-1:0] users_d [SLOTS];
  logic [SlotW-1:0]            order_q [SLOTS];
  logic [SlotW-1:0]            order_d [SLOTS];
  logic [CntW-1:0]             free_cnt_q, free_cnt_d;

  logic advance;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Decode and update
  logic [plcc_pkg::ChunkW-1:0] req_chunk;
  logic [plcc_pkg::WordW-1:0]  req_word;
  logic [SlotW-1:0]            req_slot;
  logic                        req_slot_ok;
  logic                        hit_found;
  logic [SlotW-1:0]            hit_slot;
  logic [plcc_pkg::UsersW-1:0] hit_users;
  logic [SlotW-1:0]            victim;
  logic [plcc_pkg::UsersW-1:0] rel_users;
  logic                        rm_en, rm_found, app_en;
  logic [SlotW-1:0]            rm_slot, rm_pos;

  assign req_chunk   = plcc_pkg::ChunkW'(bit_idx_q >> CHUNK_SHIFT);
  assign req_word    = bit_idx_q[plcc_pkg::WordShift +: plcc_pkg::WordW];
  assign req_slot    = SlotW'({30'd0, slot_q});
  assign req_slot_ok = ({30'd0, slot_q} < 32'(SLOTS));
  assign victim      = order_q[0];

  always_comb begin
    hit_found = 1'b0;
    hit_slot  = '0;
    hit_users = '0;
    rel_users = '0;
    // lowest matching slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (chunk_q[i] == req_chunk) begin
        hit_found = 1'b1;
        hit_slot  = SlotW'(i);
        hit_users = users_q[i];
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (SlotW'(i) == req_slot) rel_users = users_q[i];
    end
  end

  always_comb begin
    res_d   = '0;
    rm_en   = 1'b0;
    rm_slot = '0;
    app_en  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      chunk_d[i] = chunk_q[i];
      dirty_d[i] = dirty_q[i];
      users_d[i] = users_q[i];
    end
    case (action_q)
      plcc_pkg::ACT_ACQUIRE: begin
        res_d.word_offset = req_word;
        if (hit_found) begin
          res_d.slot_out = plcc_pkg::SlotPortW'(32'(hit_slot));
          res_d.hit      = 1'b1;
          if (hit_users == plcc_pkg::UsersMax) begin
            res_d.error = plcc_pkg::ERR_SATURATED;
          end else begin
            rm_en   = (hit_users == '0);
            rm_slot = hit_slot;
            for (int i = 0; i < SLOTS; i++) begin
              if (SlotW'(i) == hit_slot) users_d[i] = users_q[i] + 1'b1;
            end
          end
        end else if (free_cnt_q == '0) begin
          res_d.error = plcc_pkg::ERR_NO_FREE;
        end else begin
          rm_en            = 1'b1;
          rm_slot          = victim;
          res_d.slot_out   = plcc_pkg::SlotPortW'(32'(victim));
          res_d.fill_valid = 1'b1;
          res_d.fill_chunk = req_chunk;
          for (int i = 0; i < SLOTS; i++) begin
            if (SlotW'(i) == victim) begin
              if (dirty_q[i]) begin
                res_d.writeback_valid = 1'b1;
                res_d.writeback_chunk = chunk_q[i];
              end
              chunk_d[i] = req_chunk;
              dirty_d[i] = 1'b0;
              users_d[i] = plcc_pkg::UsersW'(1);
            end
          end
        end
      end
      plcc_pkg::ACT_RELEASE: begin
        res_d.slot_out = slot_q;
        if (!req_slot_ok || rel_users == '0) begin
          res_d.error = plcc_pkg::ERR_UNUSED;
        end else begin
          app_en = (rel_users == plcc_pkg::UsersW'(1));
          for (int i = 0; i < SLOTS; i++) begin
            if (SlotW'(i) == req_slot) users_d[i] = users_q[i] - 1'b1;
          end
        end
      end
      plcc_pkg::ACT_DIRTY: begin
        res_d.slot_out = slot_q;
        if (req_slot_ok) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (SlotW'(i) == req_slot) dirty_d[i] = 1'b1;
          end
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Free list: removal closes the gap, append goes to the tail
  always_comb begin
    rm_found = 1'b0;
    rm_pos   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (CntW'(i) < free_cnt_q && order_q[i] == rm_slot) begin
        rm_found = 1'b1;
        rm_pos   = SlotW'(i);
      end
    end
    free_cnt_d = free_cnt_q;
    for (int j = 0; j < SLOTS; j++) order_d[j] = order_q[j];
    if (rm_en && rm_found) begin
      free_cnt_d = free_cnt_q - 1'b1;
      for (int j = 0; j + 1 < SLOTS; j++) begin
        if (SlotW'(j) >= rm_pos) order_d[j] = order_q[j + 1];
      end
    end else if (app_en && free_cnt_q < CntW'(SLOTS)) begin
      free_cnt_d = free_cnt_q + 1'b1;
      for (int j = 0; j < SLOTS; j++) begin
        if (CntW'(j) == free_cnt_q) order_d[j] = req_slot;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      free_cnt_q  <= CntW'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        chunk_q[i] <= plcc_pkg::ChunkW'(i);
        dirty_q[i] <= 1'b0;
        users_q[i] <= '0;
        order_q[i] <= SlotW'(i);
      end
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
        free_cnt_q  <= free_cnt_d;
        for (int i = 0; i < SLOTS; i++) begin
          chunk_q[i] <= chunk_d[i];
          dirty_q[i] <= dirty_d[i];
          users_q[i] <= users_d[i];
          order_q[i] <= order_d[i];
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q  <= plcc_pkg::action_e'(s_axis_tuser);
      bit_idx_q <= s_axis_tdata[31:0];
      slot_q    <= s_axis_tdata[33:32];
    end
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  // Checks
  logic [SLOTS-1:0] unpinned;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) unpinned[i] = (users_q[i] == '0);
  end

  a_free_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CntW'(SLOTS))
    else $error("free count above slot count");

  a_free_matches_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(unpinned) == 32'(free_cnt_q))
    else $error("free list length differs from unpinned slots");

  a_fill_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.fill_valid |-> !res_q.hit && res_q.error == plcc_pkg::ERR_NONE)
    else $error("fill request on hit or error");

  a_wb_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.writeback_valid |-> res_q.fill_valid)
    else $error("write-back without fill");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while a stage is free");

endmodule
